/* sv/mcb_pkg.sv */
// Shared constants, types and helper functions of the mip chain box downsampler.
package mcb_pkg;

	localparam int MAX_DIM    = 4096;
	localparam int MAX_LEVELS = 13;
	localparam int DIM_W      = 13;
	localparam int CNT_W      = 12;
	localparam int LVL_W      = 4;
	localparam int POS_W      = 11;
	localparam int MEM_DEPTH  = 2 * MAX_DIM;
	localparam int ADDR_W     = 13;

	localparam logic CFG_BASE_WIDTH  = 1'b0;
	localparam logic CFG_BASE_HEIGHT = 1'b1;

	typedef logic [31:0] pix_t;

	typedef struct packed {
		logic [LVL_W-1:0] level;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row_index;
		pix_t             pix;
		logic             done;
	} res_t;

	typedef struct packed {
		logic start;
		logic eval;
		logic take;
		logic push;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic emit;
		logic hold_valid;
		logic out_free;
	} sts_t;

	// size of a level in one dimension: max(1, base >> level)
	function automatic logic [DIM_W-1:0] lvl_dim(input logic [DIM_W-1:0] b,
			input logic [LVL_W:0] s);
		logic [DIM_W-1:0] t;
		t = b >> s;
		return (t == '0) ? DIM_W'(1) : t;
	endfunction

	function automatic logic [LVL_W-1:0] lvl_count(input logic [DIM_W-1:0] m);
		logic [LVL_W-1:0] n;
		n = LVL_W'(1);
		for (int i = 0; i < DIM_W; i++) begin
			if (m[i]) n = LVL_W'(i + 1);
		end
		if (n > LVL_W'(MAX_LEVELS)) n = LVL_W'(MAX_LEVELS);
		return n;
	endfunction

	// row store region of a level: level p starts at MEM_DEPTH - (MEM_DEPTH >> p)
	function automatic logic [ADDR_W-1:0] lvl_base(input logic [LVL_W-1:0] p);
		logic [ADDR_W:0] t;
		t = (ADDR_W+1)'(MEM_DEPTH) - ((ADDR_W+1)'(MEM_DEPTH) >> p);
		return t[ADDR_W-1:0];
	endfunction

endpackage

/* sv/mcb_if.sv */
// Pixel input and result output channel interfaces.
interface mcb_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;
	logic [7:0] alpha_in;
	modport source(output valid, red_in, green_in, blue_in, alpha_in, input ready);
	modport sink(input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface mcb_res_if;
	logic        valid;
	logic        ready;
	logic [3:0]  level;
	logic [10:0] col;
	logic [10:0] row_index;
	logic [7:0]  red_out;
	logic [7:0]  green_out;
	logic [7:0]  blue_out;
	logic [7:0]  alpha_out;
	logic        last_of_run;
	logic        image_done;
	modport source(output valid, level, col, row_index, red_out, green_out, blue_out,
		alpha_out, last_of_run, image_done, input ready);
	modport sink(input valid, level, col, row_index, red_out, green_out, blue_out,
		alpha_out, last_of_run, image_done, output ready);
endinterface

/* sv/mcb_ctrl.sv */
// Controller state machine: walks one base pixel up the level chain.
module mcb_ctrl
	import mcb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_EVAL  = 4'b0010,
		S_AVG   = 4'b0100,
		S_FLUSH = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				if (sts.emit) state_d = S_AVG;
				else if (sts.hold_valid) state_d = S_FLUSH;
				else state_d = S_IDLE;
			end
			S_AVG: begin
				// earlier result is known not to be last once another follows
				if (!sts.hold_valid) begin
					cmd.take = 1'b1;
					state_d  = S_EVAL;
				end else if (sts.out_free) begin
					cmd.take = 1'b1;
					cmd.push = 1'b1;
					state_d  = S_EVAL;
				end
			end
			S_FLUSH: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					cmd.last = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule

/* sv/mcb_dp.sv */
// Datapath: level counters, row store, box average and output register.
module mcb_dp
	import mcb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [DIM_W-1:0] cfg_wdata,
	input  pix_t             in_pix,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  logic             out_ready,
	output logic             out_valid,
	output res_t             out_res,
	output logic             out_last
);

	logic [DIM_W-1:0] bw_q, bh_q, cfg_v;
	logic [CNT_W-1:0] cnt_c_q [MAX_LEVELS];
	logic [CNT_W-1:0] cnt_r_q [MAX_LEVELS];
	pix_t             held_q [MAX_LEVELS];
	pix_t             mem [MEM_DEPTH];
	pix_t             rd_a_q, rd_b_q, v_q;
	logic [LVL_W-1:0] p_q, levels;
	logic [CNT_W-1:0] c, r;
	logic [DIM_W-1:0] wp, hp, wn, hn;
	logic             cs, rs, cont, inb, wr_row, wr_held, emit;
	logic             cs_q, rs_q;
	logic [CNT_W-2:0] x_q, y_q;
	logic [ADDR_W-1:0] base, addr_a, addr_b;
	res_t             hold_q, avg_res;
	logic             hold_valid_q, out_valid_q, out_last_q;
	res_t             out_q;
	pix_t             tl, tr, bl, br, avg;
	logic [9:0]       sum;

	always_comb begin
		cfg_v = cfg_wdata;
		if (cfg_v == '0) cfg_v = DIM_W'(1);
		else if (cfg_v > DIM_W'(MAX_DIM)) cfg_v = DIM_W'(MAX_DIM);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw_q <= DIM_W'(1);
			bh_q <= DIM_W'(1);
		end else if (cfg_we) begin
			if (cfg_index == CFG_BASE_WIDTH) bw_q <= cfg_v;
			if (cfg_index == CFG_BASE_HEIGHT) bh_q <= cfg_v;
		end
	end

	assign levels = lvl_count((bw_q > bh_q) ? bw_q : bh_q);

	always_comb begin
		wp = lvl_dim(bw_q, {1'b0, p_q});
		hp = lvl_dim(bh_q, {1'b0, p_q});
		wn = lvl_dim(bw_q, {1'b0, p_q} + 1'b1);
		hn = lvl_dim(bh_q, {1'b0, p_q} + 1'b1);
		c  = cnt_c_q[p_q];
		r  = cnt_r_q[p_q];
		if ({1'b0, c} >= wp || {1'b0, r} >= hp) begin
			c = '0;
			r = '0;
		end
		cs      = (wp == DIM_W'(1));
		rs      = (hp == DIM_W'(1));
		cont    = ({1'b0, p_q} + 1'b1) < {1'b0, levels};
		inb     = (DIM_W'(c >> 1) < wn) && (DIM_W'(r >> 1) < hn);
		wr_row  = cmd.eval && cont && inb && !rs && !r[0];
		wr_held = cmd.eval && cont && inb && !cs && !c[0];
		emit    = cont && inb && (cs || c[0]) && (rs || r[0]);
		base    = lvl_base(p_q);
		addr_b  = base + ADDR_W'(c);
		addr_a  = cs ? addr_b : addr_b - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_LEVELS; i++) begin
				cnt_c_q[i] <= '0;
				cnt_r_q[i] <= '0;
			end
		end else if (cfg_we) begin
			for (int i = 0; i < MAX_LEVELS; i++) begin
				cnt_c_q[i] <= '0;
				cnt_r_q[i] <= '0;
			end
		end else if (cmd.eval) begin
			if ({1'b0, c} + 1'b1 >= wp) begin
				cnt_c_q[p_q] <= '0;
				cnt_r_q[p_q] <= ({1'b0, r} + 1'b1 >= hp) ? '0 : r + 1'b1;
			end else begin
				cnt_c_q[p_q] <= c + 1'b1;
				cnt_r_q[p_q] <= r;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_row) mem[addr_b] <= v_q;
		if (cmd.eval) begin
			rd_a_q <= mem[addr_a];
			rd_b_q <= mem[addr_b];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_held) held_q[p_q] <= v_q;
		if (cmd.eval) begin
			cs_q <= cs;
			rs_q <= rs;
			x_q  <= c[CNT_W-1:1];
			y_q  <= r[CNT_W-1:1];
		end
		if (cmd.start) v_q <= in_pix;
		else if (cmd.take) v_q <= avg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) p_q <= '0;
		else if (cmd.start) p_q <= '0;
		else if (cmd.take) p_q <= p_q + 1'b1;
	end

	always_comb begin
		if (rs_q && cs_q) begin
			tl = v_q; tr = v_q; bl = v_q; br = v_q;
		end else if (rs_q) begin
			tl = held_q[p_q]; bl = held_q[p_q]; tr = v_q; br = v_q;
		end else if (cs_q) begin
			tl = rd_b_q; tr = rd_b_q; bl = v_q; br = v_q;
		end else begin
			tl = rd_a_q; tr = rd_b_q; bl = held_q[p_q]; br = v_q;
		end
		avg = '0;
		for (int k = 0; k < 4; k++) begin
			sum = 10'(tl[8*k +: 8]) + 10'(tr[8*k +: 8]) + 10'(bl[8*k +: 8])
				+ 10'(br[8*k +: 8]);
			avg[8*k +: 8] = sum[9:2];
		end
		avg_res.level     = p_q + 1'b1;
		avg_res.col       = x_q[POS_W-1:0];
		avg_res.row_index = y_q[POS_W-1:0];
		avg_res.pix       = avg;
		avg_res.done      = ({1'b0, p_q} + 5'd2) == {1'b0, levels};
	end

	always_ff @(posedge clk) begin
		if (cmd.take) hold_q <= avg_res;
		if (cmd.push) begin
			out_q      <= hold_q;
			out_last_q <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.take) hold_valid_q <= 1'b1;
			else if (cmd.push) hold_valid_q <= 1'b0;
			if (cmd.push) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign sts.emit       = emit;
	assign sts.hold_valid = hold_valid_q;
	assign sts.out_free   = !out_valid_q || out_ready;
	assign out_valid      = out_valid_q;
	assign out_res        = out_q;
	assign out_last       = out_last_q;

endmodule

/* sv/mip_chain_box_downsampler_unit.sv */
// Mip chain generator top level: base RGBA8 pixels in, 2x2 box filtered mip pixels out.
// One base pixel is taken at a time. A pixel that completes no mip pixel passes one
// level check and returns to idle. Each mip pixel it completes adds a counter update and
// row store read, then the average. The walk then ends with one more level check and a
// step that moves the last result to the output register; a result waits while the
// output is not free. The row store is a single 8192-entry memory split by level; a
// write to either size register restarts the image.
module mip_chain_box_downsampler_unit
	import mcb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	mcb_pix_if.sink          pix_in,
	mcb_res_if.source        res_out,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [DIM_W-1:0] cfg_wdata
);

	cmd_t cmd;
	sts_t sts;
	res_t res;
	logic out_valid, out_last;

	mcb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pix_in.valid),
		.in_ready (pix_in.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mcb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_pix    ({pix_in.alpha_in, pix_in.blue_in, pix_in.green_in, pix_in.red_in}),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (res_out.ready),
		.out_valid (out_valid),
		.out_res   (res),
		.out_last  (out_last)
	);

	assign res_out.valid       = out_valid;
	assign res_out.level       = res.level;
	assign res_out.col         = res.col;
	assign res_out.row_index   = res.row_index;
	assign res_out.red_out     = res.pix[7:0];
	assign res_out.green_out   = res.pix[15:8];
	assign res_out.blue_out    = res.pix[23:16];
	assign res_out.alpha_out   = res.pix[31:24];
	assign res_out.last_of_run = out_last;
	assign res_out.image_done  = res.done;

endmodule
